### rtl/core/jls_pkg.sv
// Package for the 4x4 Jacobi solver: widths, command and status codes, FSM states.
// Used by every module of the solver but jls_ram; depends on nothing.
package jls_pkg;
  localparam int ORDER = 4;
  localparam int IDX_W = 2;
  localparam int FRAC_BITS = 24;
  localparam int WORD_BITS = 32;
  localparam int CA_W = 4;
  localparam logic [WORD_BITS-1:0] ONE_Q = 32'h0100_0000;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_SOLVE = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_NOT_CONV = 2'd2;

  localparam logic [0:0] REG_MAX_ITER = 1'b0;
  localparam logic [0:0] REG_TOL = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK_RD, S_CHK_ACC, S_CHK_END, S_INIT, S_SW_RD, S_SW_MUL, S_SW_ACC,
    S_SW_ROW, S_DELTA, S_DCHK, S_EMIT
  } state_e;

  typedef struct packed {
    logic        we;
    logic [CA_W-1:0] waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [CA_W-1:0] raddr;
  } ram_req_t;

  function automatic logic [WORD_BITS-1:0] sat_word(input logic signed [WORD_BITS+3:0] v);
    logic signed [WORD_BITS+3:0] mx;
    logic signed [WORD_BITS+3:0] mn;
    mx = {{4{1'b0}}, 1'b0, {(WORD_BITS-1){1'b1}}};
    mn = {{4{1'b1}}, 1'b1, {(WORD_BITS-1){1'b0}}};
    if (v > mx) return mx[WORD_BITS-1:0];
    if (v < mn) return mn[WORD_BITS-1:0];
    return v[WORD_BITS-1:0];
  endfunction
endpackage

### rtl/core/jls_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module jls_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/core/jls_qmul.sv
// Q8.24 multiply with truncation toward zero and saturation, one register stage.
// Depends on jls_pkg.
module jls_qmul (
  input  logic                          clk_i,
  input  logic [jls_pkg::WORD_BITS-1:0] a_i,
  input  logic [jls_pkg::WORD_BITS-1:0] b_i,
  output logic [jls_pkg::WORD_BITS-1:0] p_o
);
  localparam int W = jls_pkg::WORD_BITS;
  logic [W-1:0] ma, mb;
  logic [2*W-1:0] prod_d, prod_q;
  logic neg_d, neg_q;
  logic [2*W-1:0] sh;
  logic [W-1:0] lim;

  always_comb begin
    ma = a_i[W-1] ? (~a_i + 1'b1) : a_i;
    mb = b_i[W-1] ? (~b_i + 1'b1) : b_i;
    prod_d = ma * mb;
    neg_d = a_i[W-1] ^ b_i[W-1];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg_q <= neg_d;
  end

  always_comb begin
    sh = prod_q >> jls_pkg::FRAC_BITS;
    lim = neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    if (sh > {{W{1'b0}}, lim}) begin
      p_o = neg_q ? lim : lim;
    end else begin
      p_o = neg_q ? (~sh[W-1:0] + 1'b1) : sh[W-1:0];
    end
  end
endmodule

### rtl/core/jls_ctrl.sv
// Sequencer of the solver: convergence check, Jacobi sweeps over the coefficient
// RAM, delta norm test and result emission. Depends on jls_pkg and jls_qmul.
module jls_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [7:0]                    max_iter_i,
  input  logic [30:0]                   tol_i,
  input  logic [jls_pkg::WORD_BITS-1:0] a_rdata_i,
  output jls_pkg::ram_req_t             a_rd_o,
  input  logic [jls_pkg::WORD_BITS-1:0] b_i [jls_pkg::ORDER],
  output logic                          busy_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [jls_pkg::WORD_BITS-1:0] x_value_o,
  output logic [jls_pkg::IDX_W-1:0]     x_index_o,
  output logic [7:0]                    iterations_o,
  output logic [1:0]                    status_o,
  output logic                          last_o
);
  localparam int W = jls_pkg::WORD_BITS;
  localparam int N = jls_pkg::ORDER;
  localparam int IW = jls_pkg::IDX_W;

  jls_pkg::state_e state_q, state_d;
  logic [IW-1:0] r_q, r_d, c_q, c_d;
  logic [W+3:0] rs_q [N];
  logic [W+3:0] cs_q [N];
  logic [W-1:0] x_q [N];
  logic [W-1:0] xp_q [N];
  logic signed [W+3:0] acc_q;
  logic [2*W+3:0] dn_q;
  logic [7:0] it_q, sc_q;
  logic [1:0] st_q;
  logic conv_ok;
  logic [W-1:0] mag_a, qp, diff;
  logic [W:0] dlt, dmag;
  logic [2*W-1:0] dsq;
  logic [61:0] tsq;

  jls_qmul u_mul (.clk_i(clk_i), .a_i(a_rdata_i), .b_i(xp_q[c_q]), .p_o(qp));

  always_comb begin
    mag_a = a_rdata_i[W-1] ? (~a_rdata_i + 1'b1) : a_rdata_i;
    begin
      logic rw, cw;
      rw = 1'b0;
      cw = 1'b0;
      for (int i = 0; i < N; i++) begin
        if (rs_q[i] >= {4'd0, jls_pkg::ONE_Q}) rw = 1'b1;
        if (cs_q[i] >= {4'd0, jls_pkg::ONE_Q}) cw = 1'b1;
      end
      conv_ok = !rw || !cw;
    end
    dlt = {x_q[r_q][W-1], x_q[r_q]} - {xp_q[r_q][W-1], xp_q[r_q]};
    dmag = dlt[W] ? (~dlt + 1'b1) : dlt;
    diff = dmag[W-1:0];
    dsq = diff * diff;
    tsq = tol_i * tol_i;
  end

  always_comb begin
    state_d = state_q;
    r_d = r_q;
    c_d = c_q;
    a_rd_o = '0;
    a_rd_o.raddr = {r_q, c_q};
    unique case (state_q)
      jls_pkg::S_IDLE: begin
        r_d = '0;
        c_d = '0;
        if (start_i) state_d = jls_pkg::S_CHK_RD;
      end
      jls_pkg::S_CHK_RD: state_d = jls_pkg::S_CHK_ACC;
      jls_pkg::S_CHK_ACC: begin
        {r_d, c_d} = {r_q, c_q} + 1'b1;
        state_d = ({r_q, c_q} == '1) ? jls_pkg::S_CHK_END : jls_pkg::S_CHK_RD;
      end
      jls_pkg::S_CHK_END: state_d = conv_ok ? jls_pkg::S_INIT : jls_pkg::S_EMIT;
      jls_pkg::S_INIT: begin
        r_d = '0;
        c_d = '0;
        state_d = (it_q < max_iter_i) ? jls_pkg::S_SW_RD : jls_pkg::S_EMIT;
      end
      jls_pkg::S_SW_RD: state_d = jls_pkg::S_SW_MUL;
      jls_pkg::S_SW_MUL: state_d = jls_pkg::S_SW_ACC;
      jls_pkg::S_SW_ACC: begin
        c_d = c_q + 1'b1;
        state_d = (c_q == IW'(N - 1)) ? jls_pkg::S_SW_ROW : jls_pkg::S_SW_RD;
      end
      jls_pkg::S_SW_ROW: begin
        r_d = r_q + 1'b1;
        state_d = (r_q == IW'(N - 1)) ? jls_pkg::S_DELTA : jls_pkg::S_SW_RD;
      end
      jls_pkg::S_DELTA: begin
        r_d = r_q + 1'b1;
        if (r_q == IW'(N - 1)) state_d = jls_pkg::S_DCHK;
      end
      jls_pkg::S_DCHK: begin
        r_d = '0;
        if (dn_q < {6'd0, tsq} || it_q + 8'd1 >= max_iter_i) state_d = jls_pkg::S_EMIT;
        else state_d = jls_pkg::S_SW_RD;
      end
      jls_pkg::S_EMIT: begin
        if (out_ready_i) begin
          r_d = r_q + 1'b1;
          if (r_q == IW'(N - 1)) state_d = jls_pkg::S_IDLE;
        end
      end
      default: state_d = jls_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jls_pkg::S_IDLE;
      r_q <= '0;
      c_q <= '0;
      it_q <= '0;
      sc_q <= '0;
      st_q <= '0;
      for (int i = 0; i < N; i++) begin
        x_q[i] <= '0;
        xp_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      r_q <= r_d;
      c_q <= c_d;
      case (state_q)
        jls_pkg::S_CHK_END: begin
          if (!conv_ok) begin
            st_q <= jls_pkg::ST_NOT_CONV;
            sc_q <= '0;
          end else begin
            st_q <= jls_pkg::ST_LIMIT;
            sc_q <= (max_iter_i > 8'd0) ? max_iter_i - 8'd1 : 8'd0;
            it_q <= 8'd1;
            for (int i = 0; i < N; i++) begin
              x_q[i] <= b_i[i];
            end
          end
        end
        jls_pkg::S_INIT: begin
          for (int i = 0; i < N; i++) xp_q[i] <= x_q[i];
        end
        jls_pkg::S_SW_ROW: x_q[r_q] <= jls_pkg::sat_word(acc_q);
        jls_pkg::S_DCHK: begin
          if (dn_q < {6'd0, tsq}) begin
            st_q <= jls_pkg::ST_CONVERGED;
            sc_q <= it_q;
          end else if (it_q + 8'd1 < max_iter_i) begin
            it_q <= it_q + 8'd1;
            for (int i = 0; i < N; i++) xp_q[i] <= x_q[i];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      jls_pkg::S_IDLE: begin
        for (int i = 0; i < N; i++) begin
          rs_q[i] <= '0;
          cs_q[i] <= '0;
        end
      end
      jls_pkg::S_CHK_ACC: begin
        rs_q[r_q] <= rs_q[r_q] + {4'd0, mag_a};
        cs_q[c_q] <= cs_q[c_q] + {4'd0, mag_a};
      end
      jls_pkg::S_INIT: acc_q <= $signed({{4{b_i[0][W-1]}}, b_i[0]});
      jls_pkg::S_SW_ACC: acc_q <= acc_q + $signed({{4{qp[W-1]}}, qp});
      jls_pkg::S_SW_ROW: begin
        acc_q <= $signed({{4{b_i[r_q + 1'b1][W-1]}}, b_i[r_q + 1'b1]});
        dn_q <= '0;
      end
      jls_pkg::S_DELTA: dn_q <= dn_q + {4'd0, dsq};
      jls_pkg::S_DCHK: acc_q <= $signed({{4{b_i[0][W-1]}}, b_i[0]});
      default: ;
    endcase
  end

  assign busy_o = (state_q != jls_pkg::S_IDLE);
  assign out_valid_o = (state_q == jls_pkg::S_EMIT);
  assign x_value_o = (st_q == jls_pkg::ST_NOT_CONV) ? '0 : x_q[r_q];
  assign x_index_o = r_q;
  assign iterations_o = sc_q;
  assign status_o = st_q;
  assign last_o = (r_q == IW'(N - 1));
endmodule

### rtl/core/jacobi_linear_solver_4x4_top.sv
// Top level of the 4x4 Jacobi solver: stream ports, register file, coefficient RAM.
// Depends on jls_pkg, jls_ram and jls_ctrl.
//
// Input requests on s_axis carry matrix loads, vector loads and solve commands.
// Loads stream at one per cycle while the solver is idle.
// A solve first reads the 16 coefficients for the row and column sum check and
// then sets up. Each sweep then runs 4 rows of 4 coefficients, each through
// the coefficient RAM read and the registered multiplier, stores x once per row,
// and ends with the change norm test. The sweep count sets the solve time.
// Four result requests then leave on m_axis, x_index 0 to 3, tlast on the last.
// s_axis_tready is low from the solve until the last result is taken.
// If the receiver stalls, the current result holds on m_axis.
// Reset clears the control state, x to zero and the registers to 40 and 16777.
// Configuration writes are taken without stalling and should be made while idle.
module jacobi_linear_solver_4x4_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // row[1:0], col[3:2], value[35:4]
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // x_value[31:0], x_index[33:32], iterations[41:34], status[43:42]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [30:0] cfg_data_i
);
  localparam int W = jls_pkg::WORD_BITS;
  logic [7:0] max_iter_q;
  logic [30:0] tol_q;
  logic [W-1:0] b_q [jls_pkg::ORDER];
  logic busy;
  logic acc;
  logic [1:0] cmd;
  jls_pkg::ram_req_t rd_req, req;
  logic [W-1:0] a_rdata;
  logic [7:0] iter;
  logic [1:0] stat;
  logic [W-1:0] xv;
  logic [1:0] xi;

  assign s_axis_tready = !busy;
  assign cfg_ready_o = 1'b1;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign cmd = s_axis_tuser;

  always_comb begin
    req = rd_req;
    req.we = acc && (cmd == jls_pkg::CMD_LOAD_A);
    req.waddr = {s_axis_tdata[1:0], s_axis_tdata[3:2]};
    req.wdata = s_axis_tdata[35:4];
  end

  jls_ram #(.Width(W), .Depth(16)) u_coeff (
    .clk_i(clk_i), .we_i(req.we), .waddr_i(req.waddr), .wdata_i(req.wdata),
    .raddr_i(req.raddr), .rdata_o(a_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (acc && cmd == jls_pkg::CMD_LOAD_B) b_q[s_axis_tdata[1:0]] <= s_axis_tdata[35:4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= 8'd40;
      tol_q <= 31'd16777;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == jls_pkg::REG_MAX_ITER) max_iter_q <= cfg_data_i[7:0];
      else tol_q <= cfg_data_i;
    end
  end

  jls_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(acc && cmd == jls_pkg::CMD_SOLVE),
    .max_iter_i(max_iter_q), .tol_i(tol_q), .a_rdata_i(a_rdata), .a_rd_o(rd_req),
    .b_i(b_q), .busy_o(busy), .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .x_value_o(xv), .x_index_o(xi), .iterations_o(iter), .status_o(stat),
    .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, stat, iter, xi, xv};
endmodule

### rtl/core/jls_checker.sv
// Port-level checker for the Jacobi solver, bound to the top level.
// Depends on jls_pkg and jacobi_linear_solver_4x4_top.
module jls_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  a_no_input_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input open while results pending");
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[33:32] == 2'd3)))
    else $error("tlast does not mark index 3");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
  a_notconv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[43:42] == jls_pkg::ST_NOT_CONV |->
    m_axis_tdata[41:0] == {8'd0, m_axis_tdata[33:32], 32'd0})
    else $error("not convergent result not zero");
endmodule

bind jacobi_linear_solver_4x4_top jls_props u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
